@@ hdl/itda_pkg.sv @@
// Shared types and constants for the integer to decimal ASCII converter.
// No dependencies.
package itda_pkg;

  localparam int VAL_W         = 32;
  localparam int NUM_DIGITS    = 10;
  localparam int BCD_W         = 4 * NUM_DIGITS;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VAL_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(CONV_STEPS);
  localparam int NDIG_W        = 4;
  localparam int POS_W         = 4;
  localparam int CHAR_W        = 6;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

  // One converted number waiting for the character stage
  typedef struct packed {
    logic [BCD_W-1:0]  bcd;
    logic              neg;
    logic [NDIG_W-1:0] ndig;
  } entry_t;

endpackage

@@ hdl/int_to_decimal_ascii.sv @@
// Signed 32-bit integer to decimal ASCII text, one character per strobe.
// Depends on itda_pkg, itda_front, itda_queue and itda_back.
//
// A value is taken when start is high and busy is low. The front converts it to
// BCD (shift-and-add-3, four bits a cycle) and busy stays high through the
// conversion and the push state that hands the result to a two-entry queue; the
// push state waits while the queue is full. The back sends the text from the
// queue at one character a cycle: a '-' for a negative value, then the digits
// most significant first, with out_last on the final one; 1 to 11 characters
// per number. The front can take a new value while the back still sends the
// text of earlier ones. The receiver cannot stall: every strobed character must
// be taken in the cycle it is shown.
module int_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [itda_pkg::VAL_W-1:0]    in_value,
  output logic                          out_strobe,
  output logic [itda_pkg::CHAR_W-1:0]   out_char_code,
  output logic [itda_pkg::POS_W-1:0]    out_position,
  output logic                          out_last
);

  itda_pkg::entry_t  push_entry;
  itda_pkg::entry_t  head;
  logic              q_push, q_pop, q_full, q_empty;

  itda_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .value   (in_value),
    .busy    (busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  itda_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty)
  );

  itda_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (head),
    .q_pop         (q_pop),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_position  (out_position),
    .out_last      (out_last)
  );

  // characters of one number come without gaps and in order
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe && out_position == $past(out_position) + 4'd1)
    else $error("position did not advance within a number");

  a_new_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe || out_position == 4'd0)
    else $error("next number does not start at position zero");

  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_char_code == itda_pkg::CH_MINUS |-> out_position == 4'd0 && !out_last)
    else $error("sign character out of place");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("transfer into a full queue");

endmodule

@@ hdl/itda_front.sv @@
// Front stage: accepts a signed value, takes its magnitude and converts it to BCD
// by shift-and-add-3, four bits per cycle. Depends on itda_pkg.
module itda_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [itda_pkg::VAL_W-1:0]  value,
  output logic                        busy,
  input  logic                        q_full,
  output logic                        q_push,
  output itda_pkg::entry_t            q_entry
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam int VW = itda_pkg::BCD_W + itda_pkg::VAL_W;

  logic [1:0]                   state_r, state_nxt;
  logic [itda_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [VW-1:0]                work_r, work_nxt;
  logic                         neg_r, neg_nxt;
  logic [itda_pkg::VAL_W-1:0]   mag;
  logic [itda_pkg::NDIG_W-1:0]  ndig;
  logic                         accept;

  function automatic logic [VW-1:0] dabble(input logic [VW-1:0] v);
    logic [VW-1:0] t;
    t = v;
    for (int b = 0; b < itda_pkg::BITS_PER_STEP; b++) begin
      for (int d = 0; d < itda_pkg::NUM_DIGITS; d++) begin
        if (t[itda_pkg::VAL_W + 4*d +: 4] >= 4'd5) begin
          t[itda_pkg::VAL_W + 4*d +: 4] = t[itda_pkg::VAL_W + 4*d +: 4] + 4'd3;
        end
      end
      t = {t[VW-2:0], 1'b0};
    end
    return t;
  endfunction

  assign accept = start && (state_r == F_IDLE);
  assign busy   = (state_r != F_IDLE);
  assign mag    = value[itda_pkg::VAL_W-1] ? (~value + 1'b1) : value;

  // Highest non-zero digit sets the length; zero still gives one digit
  always_comb begin
    ndig = 4'd1;
    for (int i = 0; i < itda_pkg::NUM_DIGITS; i++) begin
      if (work_r[itda_pkg::VAL_W + 4*i +: 4] != 4'd0) begin
        ndig = itda_pkg::NDIG_W'(i + 1);
      end
    end
  end

  assign q_push        = (state_r == F_PUSH) && !q_full;
  assign q_entry.bcd   = work_r[VW-1:itda_pkg::VAL_W];
  assign q_entry.neg   = neg_r;
  assign q_entry.ndig  = ndig;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    work_nxt  = work_r;
    neg_nxt   = neg_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          work_nxt  = {{itda_pkg::BCD_W{1'b0}}, mag};
          neg_nxt   = value[itda_pkg::VAL_W-1];
          cnt_nxt   = '0;
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        work_nxt = dabble(work_r);
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == itda_pkg::STEP_W'(itda_pkg::CONV_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        // hold until the queue has room
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    neg_r  <= neg_nxt;
  end

endmodule

@@ hdl/itda_queue.sv @@
// Short FIFO of converted numbers between the front and the character stage.
// Depends on itda_pkg.
module itda_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  itda_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output itda_pkg::entry_t  head,
  output logic              empty
);

  itda_pkg::entry_t               mem_r [itda_pkg::QDEPTH];
  logic [itda_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [itda_pkg::QCNT_W-1:0]    count_r, count_nxt;

  assign full  = (count_r == itda_pkg::QCNT_W'(itda_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ hdl/itda_back.sv @@
// Character stage: takes converted numbers from the queue and sends one ASCII
// character per cycle, sign first. Depends on itda_pkg.
module itda_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  itda_pkg::entry_t              q_head,
  output logic                          q_pop,
  output logic                          out_strobe,
  output logic [itda_pkg::CHAR_W-1:0]   out_char_code,
  output logic [itda_pkg::POS_W-1:0]    out_position,
  output logic                          out_last
);

  logic                          active_r, active_nxt;
  logic                          neg_pend_r, neg_pend_nxt;
  logic [itda_pkg::NDIG_W-1:0]   rem_r, rem_nxt;
  logic [itda_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [itda_pkg::BCD_W-1:0]    dig_r, dig_nxt;
  logic                          strobe_r;
  logic [itda_pkg::CHAR_W-1:0]   char_r, char_nxt;
  logic [itda_pkg::POS_W-1:0]    opos_r;
  logic                          last_r, last_nxt;
  logic                          finishing;
  logic [5:0]                    shamt;

  assign finishing = active_r && !neg_pend_r && (rem_r == 4'd1);
  assign q_pop     = !q_empty && (!active_r || finishing);
  // left-align the most significant digit
  assign shamt     = {4'(itda_pkg::NUM_DIGITS) - q_head.ndig, 2'b00};

  always_comb begin
    char_nxt = neg_pend_r ? itda_pkg::CH_MINUS
                          : itda_pkg::CH_ZERO + {2'b00, dig_r[itda_pkg::BCD_W-1 -: 4]};
    last_nxt = !neg_pend_r && (rem_r == 4'd1);
  end

  always_comb begin
    active_nxt   = active_r;
    neg_pend_nxt = neg_pend_r;
    rem_nxt      = rem_r;
    pos_nxt      = pos_r;
    dig_nxt      = dig_r;
    if (q_pop) begin
      active_nxt   = 1'b1;
      neg_pend_nxt = q_head.neg;
      rem_nxt      = q_head.ndig;
      pos_nxt      = '0;
      dig_nxt      = q_head.bcd << shamt;
    end else if (active_r) begin
      pos_nxt = pos_r + 1'b1;
      if (neg_pend_r) begin
        neg_pend_nxt = 1'b0;
      end else begin
        dig_nxt = {dig_r[itda_pkg::BCD_W-5:0], 4'd0};
        rem_nxt = rem_r - 1'b1;
        if (rem_r == 4'd1) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      strobe_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    neg_pend_r <= neg_pend_nxt;
    rem_r      <= rem_nxt;
    pos_r      <= pos_nxt;
    dig_r      <= dig_nxt;
    char_r     <= char_nxt;
    opos_r     <= pos_r;
    last_r     <= last_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_char_code = char_r;
  assign out_position  = opos_r;
  assign out_last      = last_r;

endmodule
